// ===== hw/rtl/lscs_pkg.sv =====
// Shared types and constants for the line sensor calibration sequencer.
// No dependencies; imported by the sequencer and the bench.
package lscs_pkg;

	localparam int PADDR_W = 5;
	localparam int THR_W   = 10;
	localparam int SPEED_W = 7;
	localparam int TIME_W  = 16;

	typedef enum logic [2:0] {
		REG_OVER_LINE    = 3'd0,
		REG_NO_LINE      = 3'd1,
		REG_BETWEEN_LOW  = 3'd2,
		REG_BETWEEN_HIGH = 3'd3,
		REG_SWEEP_SPEED  = 3'd4,
		REG_CENTER_SPEED = 3'd5,
		REG_TIMEOUT      = 3'd6
	} reg_idx_t;

	typedef enum logic [5:0] {
		PH_IDLE        = 6'b000001,
		PH_SWEEP_RIGHT = 6'b000010,
		PH_SWEEP_LEFT  = 6'b000100,
		PH_CENTER      = 6'b001000,
		PH_FINISHED    = 6'b010000,
		PH_TIMEOUT     = 6'b100000
	} phase_t;

	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_SUCCESS = 2'd1,
		EV_FAILED  = 2'd2
	} event_t;

	localparam logic            ACT_TICK = 1'b0;
	localparam logic            DIR_FWD  = 1'b0;
	localparam logic            DIR_REV  = 1'b1;

	localparam logic [THR_W-1:0]   RST_OVER_LINE    = 10'd180;
	localparam logic [THR_W-1:0]   RST_NO_LINE      = 10'd90;
	localparam logic [THR_W-1:0]   RST_BETWEEN_LOW  = 10'd100;
	localparam logic [THR_W-1:0]   RST_BETWEEN_HIGH = 10'd400;
	localparam logic [SPEED_W-1:0] RST_SWEEP_SPEED  = 7'd18;
	localparam logic [SPEED_W-1:0] RST_CENTER_SPEED = 7'd15;
	localparam logic [TIME_W-1:0]  RST_TIMEOUT      = 16'd5000;

endpackage

// ===== hw/rtl/lscs_item_if.sv =====
// Input channel of the calibration sequencer: tick or step request.
// Depends on nothing; sensor width set by SENSOR_BITS.
interface lscs_item_if #(parameter int SENSOR_BITS = 10);
	logic                   valid;
	logic                   ready;
	logic                   action;
	logic [SENSOR_BITS-1:0] left_value;
	logic [SENSOR_BITS-1:0] mid_left_value;
	logic [SENSOR_BITS-1:0] middle_value;
	logic [SENSOR_BITS-1:0] mid_right_value;
	logic [SENSOR_BITS-1:0] right_value;
	logic                   left_calibrated;
	logic                   right_calibrated;
	logic                   all_calibrated;

	modport source (
		output valid, action, left_value, mid_left_value, middle_value,
		       mid_right_value, right_value, left_calibrated, right_calibrated,
		       all_calibrated,
		input  ready
	);
	modport sink (
		input  valid, action, left_value, mid_left_value, middle_value,
		       mid_right_value, right_value, left_calibrated, right_calibrated,
		       all_calibrated,
		output ready
	);
endinterface

// ===== hw/rtl/lscs_result_if.sv =====
// Result channel of the calibration sequencer: motor command and events.
// Depends on nothing.
interface lscs_result_if;
	logic       valid;
	logic       ready;
	logic       drive_update;
	logic [6:0] left_speed;
	logic       left_reverse;
	logic [6:0] right_speed;
	logic       right_reverse;
	logic       cal_start;
	logic       cal_stop;
	logic [1:0] event_res;

	modport source (
		output valid, drive_update, left_speed, left_reverse, right_speed,
		       right_reverse, cal_start, cal_stop, event_res,
		input  ready
	);
	modport sink (
		input  valid, drive_update, left_speed, left_reverse, right_speed,
		       right_reverse, cal_start, cal_stop, event_res,
		output ready
	);
endinterface

// ===== hw/rtl/line_sensor_calibration_sequencer.sv =====
// Calibration sequencer for a five-sensor line follower, with APB register port.
// Depends on lscs_pkg, lscs_item_if and lscs_result_if.
//
// One request is taken per cycle unless a step waits on a full result register.
// A request lands in an input register and is resolved from there into the result
// register. Tick requests decrement the phase timer and give no result; each step
// request gives one result. The input side keeps moving while a result waits,
// unless a second step arrives behind it; ticks drain past a waiting result.
module line_sensor_calibration_sequencer
	import lscs_pkg::*;
#(
	parameter int SENSOR_BITS = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	lscs_item_if.sink          item,
	lscs_result_if.source      result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int CW = (SENSOR_BITS > THR_W) ? SENSOR_BITS : THR_W;

	logic [THR_W-1:0]   over_q, noline_q, low_q, high_q;
	logic [SPEED_W-1:0] sweep_q, center_q;
	logic [TIME_W-1:0]  timeout_q;

	logic                   valid_s1;
	logic                   action_s1;
	logic [SENSOR_BITS-1:0] lv_s1, mlv_s1, mv_s1, mrv_s1, rv_s1;
	logic                   lcal_s1, rcal_s1, acal_s1;

	phase_t            phase_q, phase_nxt;
	logic [TIME_W-1:0] timer_count_q, timer_nxt;
	logic              timer_running_q, running_nxt;

	logic               drive_nxt, lrev_nxt, rrev_nxt, start_nxt, stop_nxt;
	logic [SPEED_W-1:0] lspd_nxt, rspd_nxt;
	event_t             ev_nxt;

	logic is_step, adv_s1, res_load, cfg_wr;
	logic expired, left_hit, right_hit, centered;

	function automatic logic [CW-1:0] ext_s(input logic [SENSOR_BITS-1:0] v);
		ext_s = CW'(v);
	endfunction

	function automatic logic [CW-1:0] ext_t(input logic [THR_W-1:0] v);
		ext_t = CW'(v);
	endfunction

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			over_q    <= RST_OVER_LINE;
			noline_q  <= RST_NO_LINE;
			low_q     <= RST_BETWEEN_LOW;
			high_q    <= RST_BETWEEN_HIGH;
			sweep_q   <= RST_SWEEP_SPEED;
			center_q  <= RST_CENTER_SPEED;
			timeout_q <= RST_TIMEOUT;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[4:2]))
				REG_OVER_LINE:    over_q    <= pwdata[THR_W-1:0];
				REG_NO_LINE:      noline_q  <= pwdata[THR_W-1:0];
				REG_BETWEEN_LOW:  low_q     <= pwdata[THR_W-1:0];
				REG_BETWEEN_HIGH: high_q    <= pwdata[THR_W-1:0];
				REG_SWEEP_SPEED:  sweep_q   <= pwdata[SPEED_W-1:0];
				REG_CENTER_SPEED: center_q  <= pwdata[SPEED_W-1:0];
				REG_TIMEOUT:      timeout_q <= pwdata[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[4:2]))
			REG_OVER_LINE:    prdata = 32'(over_q);
			REG_NO_LINE:      prdata = 32'(noline_q);
			REG_BETWEEN_LOW:  prdata = 32'(low_q);
			REG_BETWEEN_HIGH: prdata = 32'(high_q);
			REG_SWEEP_SPEED:  prdata = 32'(sweep_q);
			REG_CENTER_SPEED: prdata = 32'(center_q);
			REG_TIMEOUT:      prdata = 32'(timeout_q);
			default:          prdata = 32'd0;
		endcase
	end

	// handshake: a step in s1 moves on only when the result slot frees up
	assign is_step    = (action_s1 != ACT_TICK);
	assign adv_s1     = valid_s1 && (!is_step || !result.valid || result.ready);
	assign res_load   = adv_s1 && is_step;
	assign item.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			action_s1 <= item.action;
			lv_s1     <= item.left_value;
			mlv_s1    <= item.mid_left_value;
			mv_s1     <= item.middle_value;
			mrv_s1    <= item.mid_right_value;
			rv_s1     <= item.right_value;
			lcal_s1   <= item.left_calibrated;
			rcal_s1   <= item.right_calibrated;
			acal_s1   <= item.all_calibrated;
		end
	end

	// step decisions
	assign expired   = (timer_count_q == '0);
	assign left_hit  = lcal_s1 && (ext_s(lv_s1) > ext_t(over_q));
	assign right_hit = rcal_s1 && (ext_s(rv_s1) > ext_t(over_q));
	assign centered  = (ext_s(lv_s1) < ext_t(noline_q))
	                && (ext_s(mlv_s1) > ext_t(low_q)) && (ext_s(mlv_s1) < ext_t(high_q))
	                && (ext_s(mv_s1) > ext_t(over_q))
	                && (ext_s(mrv_s1) > ext_t(low_q)) && (ext_s(mrv_s1) < ext_t(high_q))
	                && (ext_s(rv_s1) < ext_t(noline_q));

	always_comb begin
		phase_nxt   = phase_q;
		timer_nxt   = timer_count_q;
		running_nxt = timer_running_q;
		drive_nxt   = 1'b0;
		lspd_nxt    = '0;
		lrev_nxt    = DIR_FWD;
		rspd_nxt    = '0;
		rrev_nxt    = DIR_FWD;
		start_nxt   = 1'b0;
		stop_nxt    = 1'b0;
		ev_nxt      = EV_NONE;
		if (!is_step) begin
			if (timer_running_q && !expired) begin
				timer_nxt = timer_count_q - TIME_W'(1);
			end
		end else begin
			case (phase_q)
				PH_IDLE: begin
					timer_nxt   = timeout_q;
					running_nxt = 1'b1;
					start_nxt   = 1'b1;
					phase_nxt   = PH_SWEEP_RIGHT;
				end
				PH_SWEEP_RIGHT: begin
					drive_nxt = 1'b1;
					lspd_nxt  = sweep_q;
					rspd_nxt  = sweep_q;
					rrev_nxt  = DIR_REV;
					if (expired) begin
						phase_nxt = PH_TIMEOUT;
					end
					if (left_hit) begin
						timer_nxt   = timeout_q;
						running_nxt = 1'b1;
						phase_nxt   = PH_SWEEP_LEFT;
					end
				end
				PH_SWEEP_LEFT: begin
					drive_nxt = 1'b1;
					lspd_nxt  = sweep_q;
					lrev_nxt  = DIR_REV;
					rspd_nxt  = sweep_q;
					if (expired) begin
						phase_nxt = PH_TIMEOUT;
					end
					if (right_hit) begin
						if (!acal_s1) begin
							phase_nxt = PH_SWEEP_RIGHT;
						end else begin
							timer_nxt   = timeout_q;
							running_nxt = 1'b1;
							phase_nxt   = PH_CENTER;
						end
					end
				end
				PH_CENTER: begin
					drive_nxt = 1'b1;
					lspd_nxt  = center_q;
					rspd_nxt  = center_q;
					rrev_nxt  = DIR_REV;
					if (expired) begin
						phase_nxt = PH_TIMEOUT;
					end
					if (centered) begin
						lspd_nxt    = '0;
						rspd_nxt    = '0;
						running_nxt = 1'b0;
						phase_nxt   = PH_FINISHED;
					end
				end
				PH_FINISHED: begin
					stop_nxt  = 1'b1;
					ev_nxt    = EV_SUCCESS;
					phase_nxt = PH_IDLE;
				end
				default: begin
					drive_nxt = 1'b1;
					rrev_nxt  = DIR_REV;
					stop_nxt  = 1'b1;
					ev_nxt    = EV_FAILED;
					phase_nxt = PH_TIMEOUT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_IDLE;
			timer_count_q   <= '0;
			timer_running_q <= 1'b0;
		end else if (adv_s1) begin
			phase_q         <= phase_nxt;
			timer_count_q   <= timer_nxt;
			timer_running_q <= running_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.valid <= 1'b0;
		end else if (res_load) begin
			result.valid <= 1'b1;
		end else if (result.ready) begin
			result.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			result.drive_update  <= drive_nxt;
			result.left_speed    <= lspd_nxt;
			result.left_reverse  <= lrev_nxt;
			result.right_speed   <= rspd_nxt;
			result.right_reverse <= rrev_nxt;
			result.cal_start     <= start_nxt;
			result.cal_stop      <= stop_nxt;
			result.event_res     <= ev_nxt;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.event_res == EV_FAILED) |-> (phase_q == PH_TIMEOUT))
		else $error("failure reported outside timeout phase");

	assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.cal_start) |-> (phase_q == PH_SWEEP_RIGHT))
		else $error("calibration start without right sweep");

	assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.drive_update) |->
		(result.left_speed == '0 && result.right_speed == '0))
		else $error("speed set without drive update");

	assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && !is_step && !timer_running_q) |=> $stable(timer_count_q))
		else $error("stopped timer moved on a tick");

	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_TIMEOUT) |=> (phase_q == PH_TIMEOUT))
		else $error("timeout phase left before reset");

endmodule

// ===== test/tb_top.sv =====
// Self-checking bench for line_sensor_calibration_sequencer: predicts every step result
// from its own copy of the sequencer state and checks it field by field.
// Depends on lscs_pkg, lscs_item_if, lscs_result_if and the sequencer RTL.
module tb_top;
	import lscs_pkg::*;

	localparam int   SENSOR_BITS = 10;
	localparam int   SENSOR_MAX  = (1 << SENSOR_BITS) - 1;
	localparam int   CLK_HALF    = 10;
	localparam logic ACT_STEP    = ~ACT_TICK;

	typedef logic [SENSOR_BITS-1:0] reading_t;

	typedef struct packed {
		logic     action;
		reading_t left_value;
		reading_t mid_left_value;
		reading_t middle_value;
		reading_t mid_right_value;
		reading_t right_value;
		logic     left_calibrated;
		logic     right_calibrated;
		logic     all_calibrated;
	} sensor_req_t;

	localparam int REQ_W = $bits(sensor_req_t);

	typedef struct packed {
		logic               drive_update;
		logic [SPEED_W-1:0] left_speed;
		logic               left_reverse;
		logic [SPEED_W-1:0] right_speed;
		logic               right_reverse;
		logic               cal_start;
		logic               cal_stop;
		event_t             event_res;
	} motor_cmd_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	lscs_item_if #(.SENSOR_BITS(SENSOR_BITS)) req_bus ();
	lscs_result_if cmd_bus ();

	line_sensor_calibration_sequencer #(.SENSOR_BITS(SENSOR_BITS)) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (req_bus),
		.result  (cmd_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// shadow registers and sequencer state
	logic [THR_W-1:0]   thr_over    = RST_OVER_LINE;
	logic [THR_W-1:0]   thr_no_line = RST_NO_LINE;
	logic [THR_W-1:0]   thr_low     = RST_BETWEEN_LOW;
	logic [THR_W-1:0]   thr_high    = RST_BETWEEN_HIGH;
	logic [SPEED_W-1:0] spd_sweep   = RST_SWEEP_SPEED;
	logic [SPEED_W-1:0] spd_center  = RST_CENTER_SPEED;
	logic [TIME_W-1:0]  tmo_ms      = RST_TIMEOUT;
	phase_t             cur_phase   = PH_IDLE;
	logic [TIME_W-1:0]  tmr_count   = '0;
	logic               tmr_running = 1'b0;

	motor_cmd_t pending_cmds[$];
	bit         idle_bursts = 1'b1;
	int         n_errors    = 0;
	int         n_checked   = 0;
	int         n_steps     = 0;
	int         n_ticks     = 0;
	int         n_writes    = 0;
	int         n_done      = 0;

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			n_errors++;
		end
	endfunction

	function automatic motor_cmd_t motor(input logic [SPEED_W-1:0] ls, input logic lr,
			input logic [SPEED_W-1:0] rs, input logic rr);
		motor_cmd_t c;
		c = '0;
		c.drive_update  = 1'b1;
		c.left_speed    = ls;
		c.left_reverse  = lr;
		c.right_speed   = rs;
		c.right_reverse = rr;
		return c;
	endfunction

	function automatic bit in_window(input reading_t v);
		return (v > thr_low) && (v < thr_high);
	endfunction

	task automatic load_timer();
		tmr_count   = tmo_ms;
		tmr_running = 1'b1;
	endtask

	task automatic advance_sequencer(input sensor_req_t r);
		motor_cmd_t c;
		logic       expired;
		c = '0;
		expired = (tmr_count == '0);
		if (r.action == ACT_TICK) begin
			n_ticks++;
			if (tmr_running && !expired)
				tmr_count--;
			return;
		end
		n_steps++;
		case (cur_phase)
			PH_IDLE: begin
				load_timer();
				c.cal_start = 1'b1;
				cur_phase = PH_SWEEP_RIGHT;
			end
			PH_SWEEP_RIGHT: begin
				c = motor(spd_sweep, DIR_FWD, spd_sweep, DIR_REV);
				if (expired)
					cur_phase = PH_TIMEOUT;
				if (r.left_calibrated && r.left_value > thr_over) begin
					load_timer();
					cur_phase = PH_SWEEP_LEFT;
				end
			end
			PH_SWEEP_LEFT: begin
				c = motor(spd_sweep, DIR_REV, spd_sweep, DIR_FWD);
				if (expired)
					cur_phase = PH_TIMEOUT;
				if (r.right_calibrated && r.right_value > thr_over) begin
					if (!r.all_calibrated) begin
						cur_phase = PH_SWEEP_RIGHT;
					end else begin
						load_timer();
						cur_phase = PH_CENTER;
					end
				end
			end
			PH_CENTER: begin
				c = motor(spd_center, DIR_FWD, spd_center, DIR_REV);
				if (expired)
					cur_phase = PH_TIMEOUT;
				if (r.left_value < thr_no_line && in_window(r.mid_left_value) &&
						r.middle_value > thr_over && in_window(r.mid_right_value) &&
						r.right_value < thr_no_line) begin
					c = motor('0, DIR_FWD, '0, DIR_REV);
					tmr_running = 1'b0;
					cur_phase = PH_FINISHED;
				end
			end
			PH_FINISHED: begin
				c.cal_stop = 1'b1;
				c.event_res = EV_SUCCESS;
				cur_phase = PH_IDLE;
				n_done++;
			end
			default: begin
				c = motor('0, DIR_FWD, '0, DIR_REV);
				c.cal_stop = 1'b1;
				c.event_res = EV_FAILED;
			end
		endcase
		pending_cmds.push_back(c);
	endtask

	function automatic sensor_req_t tick_req();
		sensor_req_t r;
		r = sensor_req_t'(REQ_W'({$urandom, $urandom}));
		r.action = ACT_TICK;
		return r;
	endfunction

	function automatic sensor_req_t step_req(input reading_t lv, input reading_t mlv,
			input reading_t mv, input reading_t mrv, input reading_t rv,
			input logic lcal, input logic rcal, input logic acal);
		return '{ACT_STEP, lv, mlv, mv, mrv, rv, lcal, rcal, acal};
	endfunction

	// Random step; steer it onto the current phase's exit when asked or when the timer
	// has run out, so that random traffic never falls into the terminal timeout.
	function automatic sensor_req_t make_step(input bit want_match);
		sensor_req_t r;
		r = sensor_req_t'(REQ_W'({$urandom, $urandom}));
		r.action = ACT_STEP;
		if (want_match || tmr_count == '0) begin
			case (cur_phase)
				PH_SWEEP_RIGHT: begin
					r.left_calibrated = 1'b1;
					r.left_value = reading_t'($urandom_range(thr_over + 1, SENSOR_MAX));
				end
				PH_SWEEP_LEFT: begin
					r.right_calibrated = 1'b1;
					r.right_value = reading_t'($urandom_range(thr_over + 1, SENSOR_MAX));
				end
				PH_CENTER: begin
					r.left_value      = reading_t'($urandom_range(0, thr_no_line - 1));
					r.mid_left_value  = reading_t'($urandom_range(thr_low + 1, thr_high - 1));
					r.middle_value    = reading_t'($urandom_range(thr_over + 1, SENSOR_MAX));
					r.mid_right_value = reading_t'($urandom_range(thr_low + 1, thr_high - 1));
					r.right_value     = reading_t'($urandom_range(0, thr_no_line - 1));
				end
				default: ;
			endcase
		end
		return r;
	endfunction

	task automatic send_req(input sensor_req_t r);
		if (idle_bursts && $urandom_range(0, 4) == 0) begin
			req_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		req_bus.valid            <= 1'b1;
		req_bus.action           <= r.action;
		req_bus.left_value       <= r.left_value;
		req_bus.mid_left_value   <= r.mid_left_value;
		req_bus.middle_value     <= r.middle_value;
		req_bus.mid_right_value  <= r.mid_right_value;
		req_bus.right_value      <= r.right_value;
		req_bus.left_calibrated  <= r.left_calibrated;
		req_bus.right_calibrated <= r.right_calibrated;
		req_bus.all_calibrated   <= r.all_calibrated;
		do @(posedge clk); while (!req_bus.ready);
		advance_sequencer(r);
	endtask

	// drop valid, wait for every result, then let the pipeline empty
	task automatic settle();
		req_bus.valid <= 1'b0;
		while (pending_cmds.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic apb_xfer(input logic wr, input reg_idx_t idx, input logic [31:0] wdata,
			output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= PADDR_W'({idx, 2'b00});
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] shadow_value(input reg_idx_t idx);
		case (idx)
			REG_OVER_LINE:    return 32'(thr_over);
			REG_NO_LINE:      return 32'(thr_no_line);
			REG_BETWEEN_LOW:  return 32'(thr_low);
			REG_BETWEEN_HIGH: return 32'(thr_high);
			REG_SWEEP_SPEED:  return 32'(spd_sweep);
			REG_CENTER_SPEED: return 32'(spd_center);
			REG_TIMEOUT:      return 32'(tmo_ms);
			default:          return '0;
		endcase
	endfunction

	task automatic check_reg(input reg_idx_t idx);
		logic [31:0] rd;
		apb_xfer(1'b0, idx, '0, rd);
		check_field(idx.name(), shadow_value(idx), rd);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
		logic [31:0] rd;
		apb_xfer(1'b1, idx, val, rd);
		case (idx)
			REG_OVER_LINE:    thr_over    = val[THR_W-1:0];
			REG_NO_LINE:      thr_no_line = val[THR_W-1:0];
			REG_BETWEEN_LOW:  thr_low     = val[THR_W-1:0];
			REG_BETWEEN_HIGH: thr_high    = val[THR_W-1:0];
			REG_SWEEP_SPEED:  spd_sweep   = val[SPEED_W-1:0];
			REG_CENTER_SPEED: spd_center  = val[SPEED_W-1:0];
			REG_TIMEOUT:      tmo_ms      = val[TIME_W-1:0];
			default: ;
		endcase
		n_writes++;
		check_reg(idx);
	endtask

	always @(posedge clk) begin
		motor_cmd_t want;
		if (arst_n && cmd_bus.valid && cmd_bus.ready) begin
			if (pending_cmds.size() == 0) begin
				$error("result arrived with no step request outstanding");
				n_errors++;
			end else begin
				want = pending_cmds.pop_front();
				n_checked++;
				check_field("drive_update", 32'(want.drive_update),
					32'(cmd_bus.drive_update));
				check_field("left_speed", 32'(want.left_speed), 32'(cmd_bus.left_speed));
				check_field("left_reverse", 32'(want.left_reverse),
					32'(cmd_bus.left_reverse));
				check_field("right_speed", 32'(want.right_speed), 32'(cmd_bus.right_speed));
				check_field("right_reverse", 32'(want.right_reverse),
					32'(cmd_bus.right_reverse));
				check_field("cal_start", 32'(want.cal_start), 32'(cmd_bus.cal_start));
				check_field("cal_stop", 32'(want.cal_stop), 32'(cmd_bus.cal_stop));
				check_field("event_res", 32'(want.event_res), 32'(cmd_bus.event_res));
			end
		end
	end

	initial begin
		cmd_bus.ready <= 1'b1;
		forever begin
			repeat ($urandom_range(1, 30)) @(posedge clk);
			if (idle_bursts && $urandom_range(0, 1)) begin
				cmd_bus.ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				cmd_bus.ready <= 1'b1;
			end
		end
	end

	task automatic test_register_access();
		for (int i = 0; i <= REG_TIMEOUT; i++)
			check_reg(reg_idx_t'(i));
	endtask

	task automatic test_full_calibration();
		send_req(step_req(0, 0, 0, 0, 0, 0, 0, 0));
		send_req(tick_req());
		send_req(tick_req());
		send_req(step_req(1023, 0, 0, 0, 0, 0, 1, 1));
		send_req(step_req(180, 0, 0, 0, 0, 1, 0, 0));
		send_req(step_req(181, 0, 0, 0, 0, 1, 0, 0));
		// right sensor found but not all calibrated: sweep right again
		send_req(step_req(0, 0, 0, 0, 181, 0, 1, 0));
		send_req(step_req(1023, 1023, 1023, 1023, 1023, 1, 1, 1));
		send_req(step_req(0, 0, 0, 0, 1023, 1, 1, 1));
		send_req(step_req(0, 0, 0, 0, 0, 1, 1, 1));
		send_req(step_req(89, 100, 181, 400, 89, 1, 1, 1));
		send_req(step_req(89, 101, 181, 399, 89, 1, 1, 1));
		send_req(step_req(0, 0, 0, 0, 0, 0, 0, 0));
	endtask

	// with a zero timeout every phase is expired at once; matches must still win
	task automatic test_zero_timeout_override();
		settle();
		write_reg(REG_TIMEOUT, 0);
		write_reg(REG_SWEEP_SPEED, 127);
		write_reg(REG_CENTER_SPEED, 0);
		send_req(step_req(0, 0, 0, 0, 0, 0, 0, 0));
		send_req(step_req(500, 0, 0, 0, 0, 1, 0, 0));
		send_req(step_req(0, 0, 0, 0, 500, 0, 1, 1));
		send_req(step_req(0, 200, 1023, 200, 0, 0, 0, 0));
		send_req(step_req(0, 0, 0, 0, 0, 1, 1, 1));
		settle();
		write_reg(REG_TIMEOUT, 16'hFFFF);
	endtask

	task automatic test_threshold_extremes();
		settle();
		write_reg(REG_OVER_LINE, 1023);
		write_reg(REG_SWEEP_SPEED, 0);
		write_reg(REG_CENTER_SPEED, 127);
		send_req(step_req(0, 0, 0, 0, 0, 0, 0, 0));
		send_req(step_req(1023, 0, 0, 0, 0, 1, 0, 0));
		settle();
		write_reg(REG_OVER_LINE, 0);
		send_req(step_req(0, 0, 0, 0, 0, 1, 0, 0));
		send_req(step_req(1, 0, 0, 0, 0, 1, 0, 0));
		send_req(step_req(0, 0, 0, 0, 1, 0, 1, 1));
		settle();
		write_reg(REG_NO_LINE, 0);
		write_reg(REG_BETWEEN_LOW, 1023);
		write_reg(REG_BETWEEN_HIGH, 0);
		send_req(step_req(0, 500, 1023, 500, 0, 1, 1, 1));
		settle();
		write_reg(REG_NO_LINE, 1023);
		write_reg(REG_BETWEEN_LOW, 0);
		write_reg(REG_BETWEEN_HIGH, 1023);
		send_req(step_req(1022, 1, 1, 1022, 1022, 0, 0, 0));
		send_req(step_req(1023, 1023, 1023, 1023, 1023, 1, 1, 1));
	endtask

	task automatic test_random_round(input int round_no, input int n_items);
		int lo;
		int tmo;
		settle();
		lo = $urandom_range(0, SENSOR_MAX - 2);
		case (round_no)
			0: tmo = 16'hFFFF;
			1: tmo = $urandom_range(0, 8);
			default: tmo = $urandom_range(0, 400);
		endcase
		write_reg(REG_OVER_LINE, $urandom_range(1, SENSOR_MAX - 1));
		write_reg(REG_NO_LINE, $urandom_range(1, SENSOR_MAX));
		write_reg(REG_BETWEEN_LOW, lo);
		write_reg(REG_BETWEEN_HIGH, $urandom_range(lo + 2, SENSOR_MAX));
		write_reg(REG_SWEEP_SPEED, $urandom_range(0, 127));
		write_reg(REG_CENTER_SPEED, $urandom_range(0, 127));
		write_reg(REG_TIMEOUT, tmo);
		repeat (n_items) begin
			if ($urandom_range(0, 9) < 3)
				send_req(tick_req());
			else
				send_req(make_step($urandom_range(0, 1)));
		end
	endtask

	// timeout latches until reset, so this runs last
	task automatic test_timeout_failure();
		settle();
		while (cur_phase != PH_IDLE)
			send_req(make_step(1'b1));
		settle();
		write_reg(REG_TIMEOUT, 3);
		send_req(step_req(0, 0, 0, 0, 0, 0, 0, 0));
		repeat (4) send_req(tick_req());
		send_req(step_req(1023, 0, 0, 0, 1023, 0, 1, 1));
		send_req(step_req(1023, 0, 0, 0, 1023, 1, 1, 1));
		send_req(tick_req());
		send_req(step_req(0, 500, 1023, 500, 0, 1, 1, 1));
		settle();
	endtask

	initial begin
		arst_n                   <= 1'b0;
		req_bus.valid            <= 1'b0;
		req_bus.action           <= ACT_TICK;
		req_bus.left_value       <= '0;
		req_bus.mid_left_value   <= '0;
		req_bus.middle_value     <= '0;
		req_bus.mid_right_value  <= '0;
		req_bus.right_value      <= '0;
		req_bus.left_calibrated  <= 1'b0;
		req_bus.right_calibrated <= 1'b0;
		req_bus.all_calibrated   <= 1'b0;
		psel                     <= 1'b0;
		penable                  <= 1'b0;
		pwrite                   <= 1'b0;
		paddr                    <= '0;
		pwdata                   <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_register_access();
		test_full_calibration();
		test_zero_timeout_override();
		test_threshold_extremes();
		for (int i = 0; i < 4; i++)
			test_random_round(i, 200);
		settle();
		idle_bursts = 1'b0;
		test_random_round(4, 200);
		test_timeout_failure();

		$display("Covered %0d step and %0d tick requests across %0d register writes.",
			n_steps, n_ticks, n_writes);
		$display("Checked %0d results, %0d completed calibrations, then a latched timeout.",
			n_checked, n_done);
		if (n_errors == 0)
			$display("line_sensor_calibration_sequencer test passed");
		else
			$display("line_sensor_calibration_sequencer test failed");
		$finish;
	end

	initial begin
		#(2 * CLK_HALF * 200000);
		$display("line_sensor_calibration_sequencer test failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/lscs_pkg.sv
hw/rtl/lscs_item_if.sv
hw/rtl/lscs_result_if.sv
hw/rtl/line_sensor_calibration_sequencer.sv
test/tb_top.sv
